// ----- rtl/core/skf3_pkg.sv -----
// Shared types and constants for the three-channel scalar Kalman filter.
`default_nettype none
package skf3_pkg;

    localparam int CH_W      = 2;   // channel field width
    localparam int MEAS_W    = 32;  // Q16.16 measurement / estimate width
    localparam int NOISE_W   = 24;  // Q and R register width
    localparam int ERR_W     = 25;  // stored error covariance width
    localparam int GAIN_W    = 25;  // reported gain width
    localparam int CFG_CH    = 3;   // channels that own a Q/R register pair
    localparam int CFG_IDX_W = 3;   // configuration register index width
    localparam int QUEUE_DEPTH = 2; // words held between front and back

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_Q_PRESSURE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_R_PRESSURE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_TEMPERATURE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_R_TEMPERATURE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_HUMIDITY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_R_HUMIDITY    = 3'd5;

    // Reset values of the noise registers.
    localparam logic [NOISE_W-1:0] Q_PRESSURE_RST    = 24'd16777;
    localparam logic [NOISE_W-1:0] R_PRESSURE_RST    = 24'd167772;
    localparam logic [NOISE_W-1:0] Q_TEMPERATURE_RST = 24'd16777;
    localparam logic [NOISE_W-1:0] R_TEMPERATURE_RST = 24'd167772;
    localparam logic [NOISE_W-1:0] Q_HUMIDITY_RST    = 24'd134218;
    localparam logic [NOISE_W-1:0] R_HUMIDITY_RST    = 24'd838861;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [MEAS_W-1:0] measurement;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0]          channel_out;
        logic signed [MEAS_W-1:0] estimate;
        logic [GAIN_W-1:0]        gain;
        logic [ERR_W-1:0]         error_estimate;
        logic                     bad_channel;
    } t_out_word;

    // Classified word handed from front to back.
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [MEAS_W-1:0] measurement;
        logic                     bad;
    } t_task;

    // Noise pair of one channel.
    typedef struct packed {
        logic [NOISE_W-1:0] q;
        logic [NOISE_W-1:0] r;
    } t_noise;

endpackage
`default_nettype wire

// ----- rtl/core/skf3_front.sv -----
// Front end: accepts input words, flags unserved channels, queues them for the back end.
`default_nettype none
module skf3_front #(
    parameter int CHANNELS = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire skf3_pkg::t_in_word i_in_word,
    output logic                  o_task_valid,
    input  wire                   i_task_stall,
    output skf3_pkg::t_task       o_task
);

    localparam int QD    = skf3_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);

    skf3_pkg::t_task  r_mem [QD];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic            push;
    logic            pop;
    skf3_pkg::t_task n_entry;

    assign o_in_stall   = (r_count == CNT_W'(QD));
    assign o_task_valid = (r_count != '0);
    assign o_task       = r_mem[r_rd_ptr];
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = o_task_valid && !i_task_stall;

    always_comb begin
        n_entry.channel     = i_in_word.channel;
        n_entry.measurement = i_in_word.measurement;
        n_entry.bad         = (32'(i_in_word.channel) >= 32'(CHANNELS));
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/skf3_back.sv -----
// Back end: per-channel state, bit-serial gain divider with shift-add products, result register.
`default_nettype none
module skf3_back #(
    parameter int CHANNELS      = 3,
    parameter int COV_FRAC_BITS = 24
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_task_valid,
    output logic                   o_task_stall,
    input  wire skf3_pkg::t_task   i_task,
    input  wire skf3_pkg::t_noise [skf3_pkg::CFG_CH-1:0] i_noise,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output skf3_pkg::t_out_word    o_out_word
);

    localparam int F      = COV_FRAC_BITS;
    localparam int EST_W  = skf3_pkg::MEAS_W;
    localparam int ERR_W  = skf3_pkg::ERR_W;
    localparam int NW     = skf3_pkg::NOISE_W;
    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PP_W   = ERR_W + 1;        // P + Q
    localparam int DEN_W  = PP_W + 1;         // P + Q + R
    localparam int REM_W  = DEN_W + 1;        // shifted partial remainder
    localparam int K_W    = F + 1;            // gain, up to exactly one
    localparam int INN_W  = EST_W + 1;        // innovation
    localparam int PROD_W = F + INN_W + 1;    // gain times innovation
    localparam int KP_W   = F + PP_W + 1;     // gain times predicted covariance
    localparam int DEL_W  = PROD_W - F;       // rounded correction
    localparam int SUM_W  = DEL_W + 1;        // estimate plus correction
    localparam int CNT_W  = $clog2(F + 1);

    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) << (F - 1);
    localparam logic signed [SUM_W-1:0] EST_MAX =
        {{(SUM_W - EST_W + 1){1'b0}}, {(EST_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] EST_MIN =
        {{(SUM_W - EST_W + 1){1'b1}}, {(EST_W - 1){1'b0}}};
    localparam logic [DEN_W-1:0] ERR_MAX = DEN_W'({ERR_W{1'b1}});

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;

    logic signed [EST_W-1:0] r_est [CHANNELS];
    logic [ERR_W-1:0]        r_err [CHANNELS];

    logic [skf3_pkg::CH_W-1:0] r_ch;
    logic                      r_bad;
    logic signed [EST_W-1:0]   r_x;
    logic signed [INN_W-1:0]   r_innov;
    logic [PP_W-1:0]           r_pp;
    logic [NW-1:0]             r_r;
    logic [DEN_W-1:0]          r_den;
    logic [REM_W-1:0]          r_rem;
    logic [K_W-1:0]            r_k;
    logic signed [PROD_W-1:0]  r_acc_p;
    logic [KP_W-1:0]           r_acc_k;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_valid;
    skf3_pkg::t_out_word       r_out_word;

    logic [IDX_W-1:0]          idx;
    logic [NW-1:0]             sel_q;
    logic [NW-1:0]             sel_r;
    logic signed [EST_W-1:0]   x_cur;
    logic [ERR_W-1:0]          p_cur;
    logic [REM_W-1:0]          rem_sh;
    logic                      qbit;
    logic [REM_W-1:0]          n_rem;
    logic signed [PROD_W-1:0]  n_acc_p;
    logic [KP_W-1:0]           n_acc_k;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [DEL_W-1:0]   delta;
    logic signed [SUM_W-1:0]   nx;
    logic signed [EST_W-1:0]   nx_sat;
    logic [KP_W-1:0]           p_diff;
    logic [DEN_W-1:0]          p_new;
    logic [ERR_W-1:0]          p_sat;
    logic                      out_free;
    skf3_pkg::t_out_word       n_out;

    assign o_task_stall = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign idx          = i_task.channel[IDX_W-1:0];

    // Pick the noise pair of the head word's channel.
    always_comb begin
        case (i_task.channel)
            2'd0:    begin sel_q = i_noise[0].q; sel_r = i_noise[0].r; end
            2'd1:    begin sel_q = i_noise[1].q; sel_r = i_noise[1].r; end
            2'd2:    begin sel_q = i_noise[2].q; sel_r = i_noise[2].r; end
            default: begin sel_q = '0;           sel_r = '0;           end
        endcase
    end

    always_comb begin
        x_cur = i_task.bad ? '0 : r_est[idx];
        p_cur = i_task.bad ? '0 : r_err[idx];
    end

    // One restoring-division step; the quotient bit also drives both shift-add products.
    always_comb begin
        rem_sh  = (r_cnt == '0) ? r_rem : (r_rem << 1);
        qbit    = (r_den != '0) && (rem_sh >= REM_W'(r_den));
        n_rem   = qbit ? (rem_sh - REM_W'(r_den)) : rem_sh;
        n_acc_p = (r_acc_p <<< 1) + (qbit ? PROD_W'(r_innov) : '0);
        n_acc_k = (r_acc_k << 1) + (qbit ? KP_W'(r_pp) : '0);
    end

    // Final update: rounded correction, saturation, new covariance.
    always_comb begin
        rounded = r_acc_p + ROUND;
        delta   = $signed(rounded[PROD_W-1:F]);
        nx      = SUM_W'(r_x) + SUM_W'(delta);
        if (nx > EST_MAX) begin
            nx_sat = EST_MAX[EST_W-1:0];
        end else if (nx < EST_MIN) begin
            nx_sat = EST_MIN[EST_W-1:0];
        end else begin
            nx_sat = nx[EST_W-1:0];
        end
        p_diff = KP_W'({r_pp, {F{1'b0}}}) - r_acc_k;
        p_new  = p_diff[KP_W-1:F];
        p_sat  = (p_new > ERR_MAX) ? {ERR_W{1'b1}} : p_new[ERR_W-1:0];

        n_out.channel_out = r_ch;
        if (r_bad) begin
            n_out.estimate       = '0;
            n_out.gain           = '0;
            n_out.error_estimate = '0;
            n_out.bad_channel    = 1'b1;
        end else begin
            n_out.estimate       = nx_sat;
            n_out.gain           = skf3_pkg::GAIN_W'(r_k);
            n_out.error_estimate = p_sat;
            n_out.bad_channel    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_est[i] <= '0;
                r_err[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_task_valid) begin
                        r_ch    <= i_task.channel;
                        r_bad   <= i_task.bad;
                        r_x     <= x_cur;
                        r_pp    <= PP_W'(p_cur) + PP_W'(sel_q);
                        r_r     <= sel_r;
                        r_innov <= INN_W'(i_task.measurement) - INN_W'(x_cur);
                        r_state <= i_task.bad ? S_FIN : S_PREP;
                    end
                end
                S_PREP: begin
                    r_den   <= DEN_W'(r_pp) + DEN_W'(r_r);
                    r_rem   <= REM_W'(r_pp);
                    r_k     <= '0;
                    r_acc_p <= '0;
                    r_acc_k <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= n_rem;
                    r_k     <= {r_k[K_W-2:0], qbit};
                    r_acc_p <= n_acc_p;
                    r_acc_k <= n_acc_k;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(F)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold here until the result register can take the word.
                    if (out_free) begin
                        r_out_word <= n_out;
                        if (!r_bad) begin
                            r_est[r_ch[IDX_W-1:0]] <= nx_sat;
                            r_err[r_ch[IDX_W-1:0]] <= p_sat;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/scalar_kalman_filter_three_channel.sv -----
// Three-channel scalar Kalman filter: configuration registers, front end and back end.
// Path: a word on a served channel passes the queue, then the back end's predict, divide and
//   finish states and the result register; a word on an unserved channel skips predict and divide.
// The back end takes one word at a time and no new word until it is done with the last, held by
//   the bit-serial gain divider (one quotient bit per cycle); output back-pressure holds finish.
// Reset (synchronous, active low) restores the noise registers to their defaults and
//   clears every channel's estimate and error covariance, the queue and the output valid flag.
`default_nettype none
module scalar_kalman_filter_three_channel #(
    parameter int CHANNELS      = 3,
    parameter int COV_FRAC_BITS = 24
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire skf3_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output skf3_pkg::t_out_word                o_out_word,
    input  wire                                i_cfg_we,
    input  wire [skf3_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [skf3_pkg::NOISE_W-1:0]        i_cfg_data
);

    // Noise registers, one Q/R pair per channel slot.
    logic [skf3_pkg::NOISE_W-1:0] r_q_pressure;
    logic [skf3_pkg::NOISE_W-1:0] r_r_pressure;
    logic [skf3_pkg::NOISE_W-1:0] r_q_temperature;
    logic [skf3_pkg::NOISE_W-1:0] r_r_temperature;
    logic [skf3_pkg::NOISE_W-1:0] r_q_humidity;
    logic [skf3_pkg::NOISE_W-1:0] r_r_humidity;

    skf3_pkg::t_noise [skf3_pkg::CFG_CH-1:0] noise;

    logic            task_valid;
    logic            task_stall;
    skf3_pkg::t_task task_word;

    // Take configuration writes; indexes past the last register drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_pressure    <= skf3_pkg::Q_PRESSURE_RST;
            r_r_pressure    <= skf3_pkg::R_PRESSURE_RST;
            r_q_temperature <= skf3_pkg::Q_TEMPERATURE_RST;
            r_r_temperature <= skf3_pkg::R_TEMPERATURE_RST;
            r_q_humidity    <= skf3_pkg::Q_HUMIDITY_RST;
            r_r_humidity    <= skf3_pkg::R_HUMIDITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                skf3_pkg::CFG_Q_PRESSURE:    r_q_pressure    <= i_cfg_data;
                skf3_pkg::CFG_R_PRESSURE:    r_r_pressure    <= i_cfg_data;
                skf3_pkg::CFG_Q_TEMPERATURE: r_q_temperature <= i_cfg_data;
                skf3_pkg::CFG_R_TEMPERATURE: r_r_temperature <= i_cfg_data;
                skf3_pkg::CFG_Q_HUMIDITY:    r_q_humidity    <= i_cfg_data;
                skf3_pkg::CFG_R_HUMIDITY:    r_r_humidity    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        noise[0].q = r_q_pressure;
        noise[0].r = r_r_pressure;
        noise[1].q = r_q_temperature;
        noise[1].r = r_r_temperature;
        noise[2].q = r_q_humidity;
        noise[2].r = r_r_humidity;
    end

    // Front: accept, flag unserved channels, queue.
    skf3_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .o_task_valid (task_valid),
        .i_task_stall (task_stall),
        .o_task       (task_word)
    );

    // Back: predict, divide for the gain, update state, register the result word.
    skf3_back #(
        .CHANNELS      (CHANNELS),
        .COV_FRAC_BITS (COV_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (task_valid),
        .o_task_stall (task_stall),
        .i_task       (task_word),
        .i_noise      (noise),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

endmodule
`default_nettype wire

// ----- test/skf3_result_checker.sv -----
// Result checker for the three-channel scalar Kalman filter: filter predictor and word compare.
module skf3_result_checker
    import skf3_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_in_stall,
    input  wire t_in_word             i_in_word,
    input  wire                       i_out_valid,
    input  wire                       i_out_stall,
    input  wire t_out_word            i_out_word,
    input  wire                       i_cfg_we,
    input  wire [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [NOISE_W-1:0]         i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    localparam int CHANNELS      = 3;
    localparam int COV_FRAC_BITS = 24;
    localparam int MAX_PRINTED   = 40;
    localparam longint unsigned UNITY   = 64'd1 << COV_FRAC_BITS;
    localparam longint unsigned ERR_MAX = (64'd1 << ERR_W) - 1;
    localparam longint          HALF    = longint'(1) <<< (COV_FRAC_BITS - 1);
    localparam longint          EST_MAX = 64'sd2147483647;
    localparam longint          EST_MIN = -64'sd2147483648;

    logic [NOISE_W-1:0]       q_cov     [CHANNELS];
    logic [NOISE_W-1:0]       r_cov     [CHANNELS];
    logic signed [MEAS_W-1:0] est_state [CHANNELS];
    logic [ERR_W-1:0]         err_state [CHANNELS];
    t_out_word                filter_results [$];
    int                       mismatch_count = 0;
    int                       pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    // One filter update on the predictor's own state; unserved channels leave it alone.
    function automatic t_out_word filter_step(input t_in_word w);
        t_out_word       res;
        int              ch;
        longint unsigned pp, den, k, newp;
        longint          x, innov, prod, delta, nx;
        res             = '0;
        res.channel_out = w.channel;
        ch              = int'(w.channel);
        if (ch >= CHANNELS) begin
            res.bad_channel = 1'b1;
            return res;
        end
        pp  = 64'(err_state[ch]) + 64'(q_cov[ch]);
        den = pp + 64'(r_cov[ch]);
        if (pp == 0 || den == 0)
            k = 0;
        else
            k = (pp << COV_FRAC_BITS) / den;
        if (k > UNITY)
            k = UNITY;
        x     = est_state[ch];
        innov = $signed(w.measurement) - x;
        prod  = $signed(k) * innov;
        delta = prod + HALF;
        delta = delta >>> COV_FRAC_BITS;
        nx    = x + delta;
        if (nx > EST_MAX) nx = EST_MAX;
        if (nx < EST_MIN) nx = EST_MIN;
        newp = ((UNITY - k) * pp) >> COV_FRAC_BITS;
        if (newp > ERR_MAX)
            newp = ERR_MAX;
        est_state[ch]      = nx[MEAS_W-1:0];
        err_state[ch]      = newp[ERR_W-1:0];
        res.estimate       = nx[MEAS_W-1:0];
        res.gain           = k[GAIN_W-1:0];
        res.error_estimate = newp[ERR_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            q_cov[0] = Q_PRESSURE_RST;
            r_cov[0] = R_PRESSURE_RST;
            q_cov[1] = Q_TEMPERATURE_RST;
            r_cov[1] = R_TEMPERATURE_RST;
            q_cov[2] = Q_HUMIDITY_RST;
            r_cov[2] = R_HUMIDITY_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                est_state[i] = '0;
                err_state[i] = '0;
            end
            filter_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_Q_PRESSURE:    q_cov[0] = i_cfg_data;
                    CFG_R_PRESSURE:    r_cov[0] = i_cfg_data;
                    CFG_Q_TEMPERATURE: q_cov[1] = i_cfg_data;
                    CFG_R_TEMPERATURE: r_cov[1] = i_cfg_data;
                    CFG_Q_HUMIDITY:    q_cov[2] = i_cfg_data;
                    CFG_R_HUMIDITY:    r_cov[2] = i_cfg_data;
                    default: ;
                endcase
            end
            // Check the output before queuing this edge's input.
            if (i_out_valid && !i_out_stall) begin
                if (filter_results.size() == 0) begin
                    report_mismatch("word with nothing expected", 64'(i_out_word.estimate),
                                    64'd0);
                end else begin
                    want = filter_results.pop_front();
                    if (i_out_word.channel_out !== want.channel_out)
                        report_mismatch("channel_out", 64'(i_out_word.channel_out),
                                        64'(want.channel_out));
                    if (i_out_word.estimate !== want.estimate)
                        report_mismatch("estimate", 64'(i_out_word.estimate),
                                        64'(want.estimate));
                    if (i_out_word.gain !== want.gain)
                        report_mismatch("gain", 64'(i_out_word.gain), 64'(want.gain));
                    if (i_out_word.error_estimate !== want.error_estimate)
                        report_mismatch("error_estimate", 64'(i_out_word.error_estimate),
                                        64'(want.error_estimate));
                    if (i_out_word.bad_channel !== want.bad_channel)
                        report_mismatch("bad_channel", 64'(i_out_word.bad_channel),
                                        64'(want.bad_channel));
                end
            end
            if (i_in_valid && !i_in_stall)
                filter_results.push_back(filter_step(i_in_word));
        end
        pending_count <= filter_results.size();
    end

endmodule

// ----- test/scalar_kalman_filter_three_channel_tb.sv -----
// Testbench top for the three-channel scalar Kalman filter: stimulus, idling and verdict.
module scalar_kalman_filter_three_channel_tb;
    import skf3_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 40;    // settle time after the last expected word
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [NOISE_W-1:0]   NOISE_MAX    = '1;

    localparam logic [CH_W-1:0] CH_PRESSURE    = 2'd0;
    localparam logic [CH_W-1:0] CH_TEMPERATURE = 2'd1;
    localparam logic [CH_W-1:0] CH_HUMIDITY    = 2'd2;
    localparam logic [CH_W-1:0] CH_UNSERVED    = 2'd3;

    typedef enum {KIND_DEFAULT, KIND_ZERO, KIND_NO_R, KIND_MAX, KIND_NO_Q, KIND_RANDOM}
        t_cfg_kind;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_word   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [NOISE_W-1:0]    i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;     // words still to send back to back

    // Slowly drifting level per channel, so the filters see converging sequences.
    logic signed [MEAS_W-1:0] level [3] = '{32'sd0, 32'sd0, 32'sd0};

    logic signed [MEAS_W-1:0] corner_meas [5] =
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1};

    // Phase 0 runs on reset values; the zero phase reaches a zero predicted covariance,
    // the no-R phase a gain of exactly one.
    t_cfg_kind phase_kind [PHASES] = '{KIND_DEFAULT, KIND_ZERO, KIND_NO_R, KIND_MAX,
                                       KIND_NO_Q, KIND_RANDOM, KIND_RANDOM, KIND_RANDOM};

    logic [CFG_IDX_W-1:0] q_index [3] = '{CFG_Q_PRESSURE, CFG_Q_TEMPERATURE, CFG_Q_HUMIDITY};
    logic [CFG_IDX_W-1:0] r_index [3] = '{CFG_R_PRESSURE, CFG_R_TEMPERATURE, CFG_R_HUMIDITY};

    scalar_kalman_filter_three_channel dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    skf3_result_checker result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver back-pressure: switch between stall modes at random intervals.
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 70);
            default: begin
                // Alternate long runs of stall and flow.
                if (run_left == 0) begin
                    i_out_stall <= ~i_out_stall;
                    run_left    <= $urandom_range(1, 30);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    function automatic t_in_word make_word(input logic [CH_W-1:0] ch,
                                           input logic signed [MEAS_W-1:0] meas);
        t_in_word w;
        w.channel     = ch;
        w.measurement = meas;
        return w;
    endfunction

    // Present one word, hold it until accepted, then maybe end the burst with a gap.
    task automatic send_word(input t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid, wait for every expected word, then let the datapath settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [NOISE_W-1:0] noise_pick();
        logic [NOISE_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = NOISE_W'($urandom_range(1, 1 << 16));
            1:       v = NOISE_W'($urandom_range(1 << 16, 1 << 22));
            2:       v = NOISE_W'($urandom());
            default: v = NOISE_MAX;
        endcase
        return v;
    endfunction

    // Write all six noise registers for the given kind, then the spare indexes last
    // so an aliasing decode would overwrite a live register.
    task automatic configure(input t_cfg_kind kind);
        logic [NOISE_W-1:0] q_val, r_val;
        for (int ch = 0; ch < 3; ch++) begin
            case (kind)
                KIND_ZERO: begin
                    q_val = '0;
                    r_val = '0;
                end
                KIND_NO_R: begin
                    q_val = noise_pick();
                    r_val = '0;
                end
                KIND_MAX: begin
                    q_val = NOISE_MAX;
                    r_val = NOISE_MAX;
                end
                KIND_NO_Q: begin
                    q_val = '0;
                    r_val = noise_pick();
                end
                default: begin
                    q_val = noise_pick();
                    r_val = noise_pick();
                end
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= q_index[ch];
            i_cfg_data <= q_val;
            @(posedge i_clk);
            i_cfg_idx  <= r_index[ch];
            i_cfg_data <= r_val;
            @(posedge i_clk);
        end
        i_cfg_idx  <= CFG_SPARE_LO;
        i_cfg_data <= NOISE_W'($urandom());
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SPARE_HI;
        i_cfg_data <= NOISE_W'($urandom());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        if ($urandom_range(0, 9) == 0)
            return CH_UNSERVED;
        return CH_W'($urandom_range(CH_PRESSURE, CH_HUMIDITY));
    endfunction

    function automatic logic signed [MEAS_W-1:0] rand_meas(input logic [CH_W-1:0] ch);
        logic signed [MEAS_W-1:0] m;
        case ($urandom_range(0, 9))
            0, 1, 2: m = $urandom();
            3:       m = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            4, 5:    m = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            default: begin
                if (ch == CH_UNSERVED) begin
                    m = $urandom();
                end else begin
                    // Drift the level, then add measurement noise around it.
                    level[ch] = level[ch] + ($signed($urandom_range(0, 4096)) - 2048);
                    m = level[ch] + ($signed($urandom_range(0, 1 << 14)) - (1 << 13));
                end
            end
        endcase
        return m;
    endfunction

    initial begin
        logic [CH_W-1:0] ch;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner measurements on every channel, the unserved one included.
        for (int c = 0; c < 4; c++) begin
            for (int m = 0; m < 5; m++)
                send_word(make_word(CH_W'(c), corner_meas[m]));
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase_kind[phase] != KIND_DEFAULT) begin
                wait_idle();
                configure(phase_kind[phase]);
            end
            repeat (ITEMS_PER_PHASE) begin
                ch = rand_channel();
                send_word(make_word(ch, rand_meas(ch)));
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
